// ===== rtl/core/cbh_pkg.sv =====
// Package for the chained buffer hash core.
// Holds the mixing constants and shift amounts; no dependencies.
`default_nettype none

package cbh_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned DWORD_W = 64;
   localparam int unsigned BYTE_W = 8;

   localparam logic [DWORD_W-1:0] MIX_MUL_A = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [DWORD_W-1:0] MIX_MUL_B = 64'h94d0_49bb_1331_11eb;

   localparam int unsigned MIX_SHIFT_A = 30;
   localparam int unsigned MIX_SHIFT_B = 27;
   localparam int unsigned MIX_SHIFT_C = 31;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [DWORD_W-1:0] dword_type;

endpackage

`default_nettype wire

// ===== rtl/core/chained_buffer_hash_core.sv =====
// Chained buffer hash core: 64-bit finalizer mix chained over a byte stream.
// Uses cbh_pkg for constants and types.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  first, seed, msg_length, has_byte,
//                                           data_byte, last
//  rsp      out        rsp_valid/rsp_stall  hash_value
//
// One 32x32 multiplier is shared: each 64-bit product is built from three
// partial products in ST_MUL, then folded in ST_FOLD; a mix runs two such
// multiply-and-fold passes. An item is taken in ST_IDLE, then runs one mix
// for first and one for a byte, then ST_EMIT when last is set; ST_EMIT waits
// while an earlier result still waits in the output register under rsp_stall.
// Synchronous reset clears control state and the running hash to zero.
// req_stall is high whenever the sequencer is busy; a result waits in the
// output register while the next item is taken.
`default_nettype none

module chained_buffer_hash_core
   import cbh_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_first,
   input  wire logic [WORD_W-1:0]   req_seed,
   input  wire logic [WORD_W-1:0]   req_msg_length,
   input  wire logic                req_has_byte,
   input  wire logic [BYTE_W-1:0]   req_data_byte,
   input  wire logic                req_last,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [WORD_W-1:0]        rsp_hash_value
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam logic [1:0] STEP_LAST = 2'd3;

   state_type  state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic       phase_ff, phase_in;
   logic       pend_ff, pend_in;
   logic       last_ff, last_in;
   word_type   word_ff, word_in;
   dword_type  x_ff, x_in;
   dword_type  acc_ff, acc_in;
   dword_type  prod_ff, prod_in;
   word_type   running_ff, running_in;
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_hash_ff, rsp_hash_in;

   word_type   req_word;
   dword_type  seed_pack;
   dword_type  run_pack;
   dword_type  mul_const;
   word_type   mul_a;
   word_type   mul_b;
   dword_type  mul_out;
   dword_type  fold_b;
   dword_type  fold_c;
   dword_type  byte_pack;

   assign req_word  = {{(WORD_W-BYTE_W){req_data_byte[BYTE_W-1]}}, req_data_byte};
   assign seed_pack = {req_seed, req_msg_length};
   assign run_pack  = {running_ff, req_word};
   assign mul_const = phase_ff ? MIX_MUL_B : MIX_MUL_A;
   assign fold_b    = acc_ff ^ (acc_ff >> MIX_SHIFT_B);
   assign fold_c    = acc_ff ^ (acc_ff >> MIX_SHIFT_C);
   assign byte_pack = {fold_c[WORD_W-1:0], word_ff};

   // partial product select: lo*lo, lo*hi, hi*lo
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_a = x_ff[WORD_W-1:0];
            mul_b = mul_const[WORD_W-1:0];
         end
         2'd1: begin
            mul_a = x_ff[WORD_W-1:0];
            mul_b = mul_const[DWORD_W-1:WORD_W];
         end
         default: begin
            mul_a = x_ff[DWORD_W-1:WORD_W];
            mul_b = mul_const[WORD_W-1:0];
         end
      endcase
   end

   assign mul_out = mul_a * mul_b;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      last_in      = last_ff;
      word_in      = word_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      running_in   = running_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in  = req_word;
               last_in  = req_last;
               step_in  = 2'd0;
               phase_in = 1'b0;
               if (req_first) begin
                  x_in     = seed_pack ^ (seed_pack >> MIX_SHIFT_A);
                  pend_in  = req_has_byte;
                  state_in = ST_MUL;
               end else if (req_has_byte) begin
                  x_in     = run_pack ^ (run_pack >> MIX_SHIFT_A);
                  pend_in  = 1'b0;
                  state_in = ST_MUL;
               end else if (req_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_MUL: begin
            prod_in = mul_out;
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0: ;
               2'd1: acc_in = prod_ff;
               default: acc_in[DWORD_W-1:WORD_W] =
                  acc_ff[DWORD_W-1:WORD_W] + prod_ff[WORD_W-1:0];
            endcase
            if (step_ff == STEP_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            step_in = 2'd0;
            if (!phase_ff) begin
               x_in     = fold_b;
               phase_in = 1'b1;
               state_in = ST_MUL;
            end else begin
               running_in = fold_c[WORD_W-1:0];
               phase_in   = 1'b0;
               if (pend_ff) begin
                  x_in     = byte_pack ^ (byte_pack >> MIX_SHIFT_A);
                  pend_in  = 1'b0;
                  state_in = ST_MUL;
               end else if (last_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = running_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 2'd0;
         phase_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      x_ff        <= x_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

`default_nettype wire
